// ===== design/eds_pkg.sv =====
package eds_pkg;

	// fixed field widths
	localparam int TIME_W     = 32;
	localparam int BLK_W      = 16;
	localparam int TRK_IN_W   = 16;
	localparam int DELAY_W    = 8;
	localparam int QS_W       = 7;
	localparam int CNT_W      = 32;
	localparam int SUM_W      = 48;
	localparam int IN_DATA_W  = 64;
	localparam int OUT_DATA_W = 224;
	localparam int OUT_USER_W = 2;

	// item kinds carried on s_tuser
	localparam logic OP_ENQUEUE = 1'b0;
	localparam logic OP_DONE    = 1'b1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_SCAN,
		S_SCAN_END,
		S_PICK,
		S_ACCUM,
		S_SHIFT,
		S_OUT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic enq_write;
		logic reject;
		logic busy_clr;
		logic scan_rd;
		logic pick;
		logic accum;
		logic shift_rd;
		logic occ_dec;
		logic out_load;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic op_done;
		logic full;
		logic empty;
		logic busy;
		logic scan_last;
		logic shift_last;
		logic out_free;
	} sts_t;

endpackage

// ===== design/eds_ctrl.sv =====
module eds_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  eds_pkg::sts_t sts,
	output eds_pkg::cmd_t cmd
);

	eds_pkg::state_t state_q;
	eds_pkg::state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= eds_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign s_tready = (state_q == eds_pkg::S_IDLE);

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			eds_pkg::S_IDLE: begin
				if (s_tvalid) begin
					cmd.accept = 1'b1;
					state_d    = eds_pkg::S_DECODE;
				end
			end
			eds_pkg::S_DECODE: begin
				if (sts.op_done) begin
					cmd.busy_clr = 1'b1;
					state_d      = sts.empty ? eds_pkg::S_OUT : eds_pkg::S_SCAN;
				end else if (sts.full) begin
					cmd.reject = 1'b1;
					state_d    = eds_pkg::S_OUT;
				end else begin
					cmd.enq_write = 1'b1;
					state_d       = sts.busy ? eds_pkg::S_OUT : eds_pkg::S_SCAN;
				end
			end
			eds_pkg::S_SCAN: begin
				cmd.scan_rd = 1'b1;
				if (sts.scan_last) begin
					state_d = eds_pkg::S_SCAN_END;
				end
			end
			eds_pkg::S_SCAN_END: begin
				state_d = eds_pkg::S_PICK;
			end
			eds_pkg::S_PICK: begin
				cmd.pick = 1'b1;
				state_d  = eds_pkg::S_ACCUM;
			end
			eds_pkg::S_ACCUM: begin
				cmd.accum = 1'b1;
				state_d   = eds_pkg::S_SHIFT;
			end
			eds_pkg::S_SHIFT: begin
				if (sts.shift_last) begin
					cmd.occ_dec = 1'b1;
					state_d     = eds_pkg::S_OUT;
				end else begin
					cmd.shift_rd = 1'b1;
				end
			end
			eds_pkg::S_OUT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = eds_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = eds_pkg::S_IDLE;
			end
		endcase
	end

endmodule

// ===== design/eds_dpath.sv =====
module eds_dpath #(
	parameter int QUEUE_DEPTH = 64,
	parameter int TRACK_BITS  = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  eds_pkg::cmd_t                      cmd,
	output eds_pkg::sts_t                      sts,
	input  logic [eds_pkg::IN_DATA_W-1:0]      s_tdata,
	input  logic                               s_tuser,
	input  logic                               cfg_we,
	input  logic [eds_pkg::DELAY_W-1:0]        cfg_wdata,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [eds_pkg::OUT_DATA_W-1:0]     m_tdata,
	output logic [eds_pkg::OUT_USER_W-1:0]     m_tuser
);

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int TB = TRACK_BITS;
	localparam int EW = TB + eds_pkg::BLK_W + eds_pkg::TIME_W;

	// input fields
	logic [eds_pkg::TIME_W-1:0]   in_now;
	logic [eds_pkg::TRK_IN_W-1:0] in_trk;
	logic [eds_pkg::BLK_W-1:0]    in_blk;
	assign in_now = s_tdata[31:0];
	assign in_trk = s_tdata[47:32];
	assign in_blk = s_tdata[63:48];

	// scheduler state
	logic                          op_q;
	logic [eds_pkg::TIME_W-1:0]    itime_q;
	logic [EW-1:0]                 ent_in_q;
	logic [eds_pkg::DELAY_W-1:0]   delay_q;
	logic [CW-1:0]                 occ_q;
	logic [CW-1:0]                 peak_q;
	logic [CW-1:0]                 cnt_q;
	logic [TB-1:0]                 head_q;
	logic                          dir_q;
	logic                          busy_q;
	logic [eds_pkg::CNT_W-1:0]     rev_q;
	logic [eds_pkg::TIME_W-1:0]    wpeak_q;
	logic [eds_pkg::SUM_W-1:0]     wsum_q;

	// per-item result
	logic                          res_issued_q;
	logic                          res_rejected_q;
	logic [eds_pkg::TRK_IN_W-1:0]  res_trk_q;
	logic [eds_pkg::BLK_W-1:0]     res_blk_q;
	logic [eds_pkg::TIME_W-1:0]    res_itime_q;
	logic [eds_pkg::TIME_W-1:0]    res_wait_q;

	// scan candidates, one per side of the head
	logic                          up_found_q;
	logic [TB-1:0]                 up_d_q;
	logic [AW-1:0]                 up_idx_q;
	logic [EW-1:0]                 up_ent_q;
	logic                          dn_found_q;
	logic [TB-1:0]                 dn_d_q;
	logic [AW-1:0]                 dn_idx_q;
	logic [EW-1:0]                 dn_ent_q;

	// read pipeline
	logic                          rdv_s1;
	logic [AW-1:0]                 ridx_s1;
	logic                          sv_s1;
	logic [AW-1:0]                 sidx_s1;
	logic [EW-1:0]                 rd_data_q;

	// output register
	logic                          m_tvalid_q;
	logic [eds_pkg::OUT_DATA_W-1:0] m_tdata_q;
	logic [eds_pkg::OUT_USER_W-1:0] m_tuser_q;

	// request queue memory, oldest entry at index zero
	logic [EW-1:0] mem [QUEUE_DEPTH];
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [AW-1:0] mem_raddr;
	logic [EW-1:0] mem_wdata;

	logic [CW:0]   cnt_p1;
	assign cnt_p1    = {1'b0, cnt_q} + (CW+1)'(1);
	assign mem_we    = cmd.enq_write | sv_s1;
	assign mem_waddr = sv_s1 ? sidx_s1 : occ_q[AW-1:0];
	assign mem_wdata = sv_s1 ? rd_data_q : ent_in_q;
	assign mem_raddr = cmd.shift_rd ? cnt_p1[AW-1:0] : cnt_q[AW-1:0];

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rd_data_q <= mem[mem_raddr];
	end

	// status
	assign sts.op_done    = (op_q == eds_pkg::OP_DONE);
	assign sts.full       = (occ_q == CW'(QUEUE_DEPTH));
	assign sts.empty      = (occ_q == '0);
	assign sts.busy       = busy_q;
	assign sts.scan_last  = (cnt_p1 == {1'b0, occ_q});
	assign sts.shift_last = (cnt_p1 >= {1'b0, occ_q});
	assign sts.out_free   = !m_tvalid_q || m_tready;

	// scan compare on the entry read last cycle
	logic [TB-1:0] rd_trk;
	logic [TB-1:0] d_up;
	logic [TB-1:0] d_dn;
	logic          upd_up;
	logic          upd_dn;
	assign rd_trk = rd_data_q[TB-1:0];
	assign d_up   = rd_trk - head_q;
	assign d_dn   = head_q - rd_trk;
	assign upd_up = rdv_s1 && (rd_trk >= head_q) && (!up_found_q || (d_up < up_d_q));
	assign upd_dn = rdv_s1 && (rd_trk <= head_q) && (!dn_found_q || (d_dn < dn_d_q));

	// pick: stay on the sweep side if it has a request, otherwise reverse
	logic          reverse;
	logic          take_up;
	logic [EW-1:0] sel_ent;
	logic [AW-1:0] sel_idx;
	assign reverse = (dir_q == 1'b0) ? !up_found_q : !dn_found_q;
	assign take_up = (dir_q == 1'b0) ? up_found_q : !dn_found_q;
	assign sel_ent = take_up ? up_ent_q : dn_ent_q;
	assign sel_idx = take_up ? up_idx_q : dn_idx_q;

	// saturating wait sum
	logic [eds_pkg::SUM_W:0] sum_ext;
	assign sum_ext = {1'b0, wsum_q} + (eds_pkg::SUM_W+1)'(res_wait_q);

	// control and statistics registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q    <= eds_pkg::DELAY_W'(1);
			occ_q      <= '0;
			peak_q     <= '0;
			cnt_q      <= '0;
			head_q     <= '0;
			dir_q      <= 1'b0;
			busy_q     <= 1'b0;
			rev_q      <= '0;
			wpeak_q    <= '0;
			wsum_q     <= '0;
			up_found_q <= 1'b0;
			dn_found_q <= 1'b0;
			rdv_s1     <= 1'b0;
			sv_s1      <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				delay_q <= cfg_wdata;
			end
			rdv_s1 <= cmd.scan_rd;
			sv_s1  <= cmd.shift_rd;
			if (cmd.accept) begin
				cnt_q      <= '0;
				up_found_q <= 1'b0;
				dn_found_q <= 1'b0;
			end
			if (cmd.busy_clr) begin
				busy_q <= 1'b0;
			end
			// enqueue grows the queue and tracks the peak
			if (cmd.enq_write) begin
				occ_q <= occ_q + CW'(1);
				if ((occ_q + CW'(1)) > peak_q) begin
					peak_q <= occ_q + CW'(1);
				end
			end
			if (cmd.scan_rd || cmd.shift_rd) begin
				cnt_q <= cnt_p1[CW-1:0];
			end
			if (upd_up) begin
				up_found_q <= 1'b1;
			end
			if (upd_dn) begin
				dn_found_q <= 1'b1;
			end
			// issue the chosen request
			if (cmd.pick) begin
				head_q <= sel_ent[TB-1:0];
				busy_q <= 1'b1;
				cnt_q  <= CW'(sel_idx);
				if (reverse) begin
					dir_q <= ~dir_q;
					rev_q <= rev_q + eds_pkg::CNT_W'(1);
				end
			end
			if (cmd.accum) begin
				if (res_wait_q > wpeak_q) begin
					wpeak_q <= res_wait_q;
				end
				wsum_q <= sum_ext[eds_pkg::SUM_W] ? '1 : sum_ext[eds_pkg::SUM_W-1:0];
			end
			if (cmd.occ_dec) begin
				occ_q <= occ_q - CW'(1);
			end
			if (cmd.out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		ridx_s1 <= cnt_q[AW-1:0];
		sidx_s1 <= cnt_q[AW-1:0];
		if (cmd.accept) begin
			op_q           <= s_tuser;
			itime_q        <= in_now + eds_pkg::TIME_W'(delay_q);
			ent_in_q       <= {in_now, in_blk, TB'(in_trk)};
			res_issued_q   <= 1'b0;
			res_rejected_q <= 1'b0;
			res_trk_q      <= '0;
			res_blk_q      <= '0;
			res_itime_q    <= '0;
			res_wait_q     <= '0;
		end
		if (cmd.reject) begin
			res_rejected_q <= 1'b1;
		end
		if (upd_up) begin
			up_d_q   <= d_up;
			up_idx_q <= ridx_s1;
			up_ent_q <= rd_data_q;
		end
		if (upd_dn) begin
			dn_d_q   <= d_dn;
			dn_idx_q <= ridx_s1;
			dn_ent_q <= rd_data_q;
		end
		if (cmd.pick) begin
			res_issued_q <= 1'b1;
			res_trk_q    <= eds_pkg::TRK_IN_W'(sel_ent[TB-1:0]);
			res_blk_q    <= sel_ent[TB +: eds_pkg::BLK_W];
			res_itime_q  <= itime_q;
			res_wait_q   <= itime_q - sel_ent[TB+eds_pkg::BLK_W +: eds_pkg::TIME_W];
		end
		if (cmd.out_load) begin
			m_tdata_q <= {1'b0, wsum_q, wpeak_q, rev_q, dir_q,
				eds_pkg::QS_W'(peak_q), eds_pkg::QS_W'(occ_q),
				res_wait_q, res_itime_q, res_blk_q, res_trk_q};
			m_tuser_q <= {res_rejected_q, res_issued_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	// checks
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= CW'(QUEUE_DEPTH))
		else $error("queue occupancy beyond depth");

	a_peak_cover: assert property (@(posedge clk) disable iff (!arst_n)
		peak_q >= occ_q)
		else $error("peak occupancy below occupancy");

	a_shift_range: assert property (@(posedge clk) disable iff (!arst_n)
		sv_s1 |-> ({1'b0, sidx_s1} < (AW+1)'(occ_q)))
		else $error("compaction write outside queued entries");

	a_pick_found: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pick |-> (up_found_q || dn_found_q))
		else $error("issue without a candidate");

endmodule

// ===== design/elevator_disk_request_scheduler_top.sv =====
// channel   dir  handshake          tdata / tuser
// s_axis    in   s_tvalid/s_tready  now_time, req_track, req_blocks / opcode
// m_axis    out  m_tvalid/m_tready  issue and statistics fields / issued, rejected
// cfg       in   cfg_we             issue_delay
//
// an enqueue to a busy disk or a full queue, and a done on an empty queue,
// go from acceptance through S_DECODE and S_OUT into the output register
// for an issue, one memory read port scans every queued entry, then the same
// port compacts the queue behind the pick
// reset (arst_n low) empties the queue, clears statistics and sets issue_delay to 1
// a new transaction is taken only after the previous result is in the output register
module elevator_disk_request_scheduler_top #(
	parameter int QUEUE_DEPTH = 64,
	parameter int TRACK_BITS  = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// now_time[31:0], req_track[47:32], req_blocks[63:48]
	input  logic [eds_pkg::IN_DATA_W-1:0]     s_tdata,
	// opcode[0]
	input  logic                              s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// issue_track[15:0], issue_blocks[31:16], issue_time[63:32], wait_time[95:64],
	// queue_size[102:96], peak_queue_size[109:103], sweep_direction[110],
	// reversal_count[142:111], longest_wait[174:143], summed_wait[222:175], zero[223]
	output logic [eds_pkg::OUT_DATA_W-1:0]    m_tdata,
	// issued[0], rejected[1]
	output logic [eds_pkg::OUT_USER_W-1:0]    m_tuser,
	input  logic                              cfg_we,
	input  logic [eds_pkg::DELAY_W-1:0]       cfg_wdata
);

	eds_pkg::cmd_t cmd;
	eds_pkg::sts_t sts;

	// sequencer
	eds_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// queue, selection and statistics
	eds_dpath #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.TRACK_BITS  (TRACK_BITS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

endmodule
